// ----- design/mvf_pkg.sv -----
// ----------------------------------------------------------------------------
// mvf_pkg: shared types and constants of the mother vertex finder
// Request and result layouts, command codes, sequencer states and defaults.
// ----------------------------------------------------------------------------
package mvf_pkg;

  localparam int MAX_VERTICES_DEF = 64;
  localparam int VERTEX_W = 6;
  localparam int COUNT_W = 7;
  localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

  localparam logic CMD_ADD = 1'b0;
  localparam logic CMD_FIND = 1'b1;

  typedef struct packed {
    logic                command;
    logic [VERTEX_W-1:0] source_vertex;
    logic [VERTEX_W-1:0] target_vertex;
  } request_t;

  typedef struct packed {
    logic [VERTEX_W-1:0] mother_vertex;
    logic                found;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_WR,
    ST_SCAN,
    ST_POP,
    ST_ROW,
    ST_LOAD,
    ST_PUSH,
    ST_CHECK
  } state_t;

endpackage

// ----- design/mvf_ram.sv -----
// ----------------------------------------------------------------------------
// mvf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module mvf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- design/mvf_lowbit.sv -----
// ----------------------------------------------------------------------------
// mvf_lowbit: lowest set bit unit
// Gives the index of the lowest set bit of a word and the word without it.
// ----------------------------------------------------------------------------
module mvf_lowbit #(
  parameter int WIDTH = mvf_pkg::MAX_VERTICES_DEF,
  parameter int IW = $clog2(mvf_pkg::MAX_VERTICES_DEF)
) (
  input  logic [WIDTH-1:0] bits,
  output logic [IW-1:0]    index,
  output logic [WIDTH-1:0] rest
);

  logic [WIDTH-1:0] lowest;

  assign lowest = bits & (~bits + WIDTH'(1));
  assign rest = bits & ~lowest;

  always_comb begin
    index = '0;
    for (int k = 0; k < WIDTH; k++) begin
      if (lowest[k]) begin
        index = index | IW'(k);
      end
    end
  end

endmodule

// ----- design/mother_vertex_finder.sv -----
// ----------------------------------------------------------------------------
// mother_vertex_finder: mother vertex search over a directed graph
// Stores the edges as a bit matrix and finds a vertex that reaches all others.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. An add request sets
// the edge from source to target: the row is read, then written back. An add
// with either vertex at or above the vertex count (read as one when zero) is
// dropped, and the block is ready again on the next cycle.
// A find request walks the graph with a depth-first stack and returns one
// result: done is high for exactly one cycle with the result on its port.
// The receiver cannot stall, so the result is simply presented for that cycle.
// In a find, each popped vertex passes through pop, stack read, row merge and a
// closing push check, each pushed vertex goes through the lowest set bit unit,
// and the scan steps over the vertices in use. Busy stays high for the whole
// walk and drops in the cycle where done is high.
// The vertex count is to be written through cfg_valid and cfg_data only while
// the block is idle; the block itself does not enforce this. cfg_ready is
// always high. Reset clears the graph through per-row valid bits at once, sets
// the vertex count to 64 and leaves the block idle.
// ----------------------------------------------------------------------------
module mother_vertex_finder #(
  parameter int MAX_VERTICES = mvf_pkg::MAX_VERTICES_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  mvf_pkg::request_t            request,
  output logic                         done,
  output mvf_pkg::result_t             result,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [mvf_pkg::COUNT_W-1:0]  cfg_data
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);

  mvf_pkg::state_t state, state_next;

  logic [mvf_pkg::COUNT_W-1:0] vertex_count;
  logic [MAX_VERTICES-1:0]     row_valid, row_valid_next;
  logic [MAX_VERTICES-1:0]     reached, reached_next;
  logic [MAX_VERTICES-1:0]     lim, lim_next, lim_calc;
  logic [MAX_VERTICES-1:0]     fresh, fresh_next;
  logic [NW-1:0]               sp, sp_next, sp_dec;
  logic [NW-1:0]               idx, idx_next;
  logic [NW-1:0]               n_active;
  logic [VW-1:0]               cand, cand_next;
  logic [VW-1:0]               cur, cur_next;
  logic [VW-1:0]               add_row, add_row_next;
  logic [VW-1:0]               add_col, add_col_next;
  logic                        pass, pass_next;
  logic                        done_next;
  mvf_pkg::result_t            result_next;

  logic                        edge_we;
  logic [VW-1:0]               edge_waddr, edge_raddr;
  logic [MAX_VERTICES-1:0]     edge_wdata, edge_rdata, row_sel;
  logic                        stack_we;
  logic [VW-1:0]               stack_waddr, stack_raddr, stack_wdata, stack_rdata;
  logic [VW-1:0]               low_index;
  logic [MAX_VERTICES-1:0]     low_rest;

  mvf_ram #(
    .WIDTH(MAX_VERTICES),
    .DEPTH(MAX_VERTICES)
  ) u_edge_ram (
    .clk  (clk),
    .we   (edge_we),
    .waddr(edge_waddr),
    .wdata(edge_wdata),
    .raddr(edge_raddr),
    .rdata(edge_rdata)
  );

  mvf_ram #(
    .WIDTH(VW),
    .DEPTH(MAX_VERTICES)
  ) u_stack_ram (
    .clk  (clk),
    .we   (stack_we),
    .waddr(stack_waddr),
    .wdata(stack_wdata),
    .raddr(stack_raddr),
    .rdata(stack_rdata)
  );

  mvf_lowbit #(
    .WIDTH(MAX_VERTICES),
    .IW   (VW)
  ) u_lowbit (
    .bits (fresh),
    .index(low_index),
    .rest (low_rest)
  );

  assign busy = (state != mvf_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;
  assign sp_dec = sp - NW'(1);

  always_comb begin
    if (vertex_count == '0) begin
      n_active = NW'(1);
    end else if (int'(vertex_count) > MAX_VERTICES) begin
      n_active = NW'(MAX_VERTICES);
    end else begin
      n_active = NW'(vertex_count);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      lim_calc[k] = (k < int'(n_active));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count <= mvf_pkg::VERTEX_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      vertex_count <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mvf_pkg::ST_IDLE;
      row_valid <= '0;
      reached <= '0;
      done <= 1'b0;
      sp <= '0;
    end else begin
      state <= state_next;
      row_valid <= row_valid_next;
      reached <= reached_next;
      done <= done_next;
      sp <= sp_next;
    end
  end

  always_ff @(posedge clk) begin
    lim <= lim_next;
    fresh <= fresh_next;
    idx <= idx_next;
    cand <= cand_next;
    cur <= cur_next;
    add_row <= add_row_next;
    add_col <= add_col_next;
    pass <= pass_next;
    result <= result_next;
  end

  always_comb begin
    state_next = state;
    row_valid_next = row_valid;
    reached_next = reached;
    lim_next = lim;
    fresh_next = fresh;
    sp_next = sp;
    idx_next = idx;
    cand_next = cand;
    cur_next = cur;
    add_row_next = add_row;
    add_col_next = add_col;
    pass_next = pass;
    done_next = 1'b0;
    result_next = result;

    edge_we = 1'b0;
    edge_waddr = add_row;
    edge_wdata = '0;
    edge_raddr = VW'(request.source_vertex);
    stack_we = 1'b0;
    stack_waddr = sp[VW-1:0];
    stack_wdata = low_index;
    stack_raddr = sp_dec[VW-1:0];
    row_sel = '0;

    case (state)
      mvf_pkg::ST_IDLE: begin
        if (start) begin
          if (request.command == mvf_pkg::CMD_ADD) begin
            add_row_next = VW'(request.source_vertex);
            add_col_next = VW'(request.target_vertex);
            if ((int'(request.source_vertex) < int'(n_active)) &&
                (int'(request.target_vertex) < int'(n_active))) begin
              state_next = mvf_pkg::ST_ADD_WR;
            end
          end else begin
            reached_next = '0;
            lim_next = lim_calc;
            idx_next = '0;
            cand_next = '0;
            pass_next = 1'b0;
            sp_next = '0;
            state_next = mvf_pkg::ST_SCAN;
          end
        end
      end

      mvf_pkg::ST_ADD_WR: begin
        if (row_valid[add_row]) begin
          row_sel = edge_rdata;
        end
        edge_we = 1'b1;
        edge_wdata = row_sel | (MAX_VERTICES'(1) << add_col);
        row_valid_next[add_row] = 1'b1;
        state_next = mvf_pkg::ST_IDLE;
      end

      mvf_pkg::ST_SCAN: begin
        if (idx == n_active) begin
          reached_next = '0;
          reached_next[cand] = 1'b1;
          stack_we = 1'b1;
          stack_waddr = '0;
          stack_wdata = cand;
          sp_next = NW'(1);
          pass_next = 1'b1;
          state_next = mvf_pkg::ST_POP;
        end else if (!reached[idx[VW-1:0]]) begin
          cand_next = idx[VW-1:0];
          reached_next[idx[VW-1:0]] = 1'b1;
          stack_we = 1'b1;
          stack_waddr = sp[VW-1:0];
          stack_wdata = idx[VW-1:0];
          sp_next = sp + NW'(1);
          state_next = mvf_pkg::ST_POP;
        end else begin
          idx_next = idx + NW'(1);
        end
      end

      mvf_pkg::ST_POP: begin
        if (sp == '0) begin
          if (pass) begin
            state_next = mvf_pkg::ST_CHECK;
          end else begin
            idx_next = idx + NW'(1);
            state_next = mvf_pkg::ST_SCAN;
          end
        end else begin
          sp_next = sp_dec;
          state_next = mvf_pkg::ST_ROW;
        end
      end

      mvf_pkg::ST_ROW: begin
        edge_raddr = stack_rdata;
        cur_next = stack_rdata;
        state_next = mvf_pkg::ST_LOAD;
      end

      mvf_pkg::ST_LOAD: begin
        if (row_valid[cur]) begin
          row_sel = edge_rdata;
        end
        fresh_next = row_sel & ~reached & lim;
        reached_next = reached | (row_sel & lim);
        state_next = mvf_pkg::ST_PUSH;
      end

      mvf_pkg::ST_PUSH: begin
        if (fresh == '0) begin
          state_next = mvf_pkg::ST_POP;
        end else begin
          stack_we = 1'b1;
          stack_waddr = sp[VW-1:0];
          stack_wdata = low_index;
          sp_next = sp + NW'(1);
          fresh_next = low_rest;
        end
      end

      mvf_pkg::ST_CHECK: begin
        done_next = 1'b1;
        if (&(reached | ~lim)) begin
          result_next.found = 1'b1;
          result_next.mother_vertex = mvf_pkg::VERTEX_W'(cand);
        end else begin
          result_next.found = 1'b0;
          result_next.mother_vertex = '0;
        end
        state_next = mvf_pkg::ST_IDLE;
      end

      default: begin
        state_next = mvf_pkg::ST_IDLE;
      end
    endcase
  end

  // A result is only ever presented once the sequencer is back at rest.
  assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("result strobe while busy");

  // Every vertex is pushed at most once per walk, so the stack cannot overflow.
  assert property (@(posedge clk) disable iff (rst) int'(sp) <= MAX_VERTICES)
    else $error("walk stack overflow");

  // A missing mother vertex is reported as vertex zero.
  assert property (@(posedge clk) disable iff (rst)
    (done && !result.found) |-> (result.mother_vertex == '0))
    else $error("nonzero vertex without found flag");

  // No result can come in the cycle right after a request.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> !done)
    else $error("result strobe right after a request");

endmodule
